### design/wvd_pkg.sv
package wvd_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int NUM_BANDS   = 8;
	localparam int IDX_WIDTH   = $clog2(NUM_BANDS);
	localparam int READ_WIDTH  = 10;

	localparam logic [IDX_WIDTH-1:0] DIR_N  = 3'd0;
	localparam logic [IDX_WIDTH-1:0] DIR_NE = 3'd1;
	localparam logic [IDX_WIDTH-1:0] DIR_E  = 3'd2;
	localparam logic [IDX_WIDTH-1:0] DIR_SE = 3'd3;
	localparam logic [IDX_WIDTH-1:0] DIR_S  = 3'd4;
	localparam logic [IDX_WIDTH-1:0] DIR_SW = 3'd5;
	localparam logic [IDX_WIDTH-1:0] DIR_W  = 3'd6;
	localparam logic [IDX_WIDTH-1:0] DIR_NW = 3'd7;

	localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_BANDS - 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic                 hit;
		logic [IDX_WIDTH-1:0] code;
	} band_t;

	typedef struct packed {
		logic                 inc;
		logic                 scan;
		logic                 last;
		logic [IDX_WIDTH-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_status_t;

	// Readings on a band limit are reported as misses.
	function automatic band_t band_of(input logic [READ_WIDTH-1:0] r);
		band_t b;
		b.hit  = 1'b1;
		b.code = DIR_N;
		if (r == 10'd0 || r == 10'd100 || r == 10'd200 || r == 10'd350 ||
		    r == 10'd450 || r == 10'd650 || r == 10'd800 || r == 10'd900) begin
			b.hit = 1'b0;
		end else if (r < 10'd100) begin
			b.code = DIR_W;
		end else if (r < 10'd200) begin
			b.code = DIR_NW;
		end else if (r < 10'd350) begin
			b.code = DIR_N;
		end else if (r < 10'd450) begin
			b.code = DIR_SW;
		end else if (r < 10'd650) begin
			b.code = DIR_NE;
		end else if (r < 10'd800) begin
			b.code = DIR_S;
		end else if (r < 10'd900) begin
			b.code = DIR_SE;
		end else begin
			b.code = DIR_E;
		end
		return b;
	endfunction

endpackage

### design/wvd_ctrl.sv
module wvd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  wvd_pkg::dp_status_t    status,
	output wvd_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [wvd_pkg::IDX_WIDTH-1:0]  idx_q;
	logic                           accept;

	assign in_ready = (state_q == ST_IDLE) && (!mode || !status.out_full);
	assign accept   = in_valid && in_ready;

	assign cmd.inc  = accept && !mode;
	assign cmd.scan = (state_q == ST_SCAN);
	assign cmd.last = (state_q == ST_SCAN) && (idx_q == wvd_pkg::LAST_IDX);
	assign cmd.idx  = idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == wvd_pkg::LAST_IDX) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) idx_q <= idx_q + 1'b1;
			else idx_q <= '0;
		end
	end

endmodule

### design/wvd_dp.sv
module wvd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [wvd_pkg::READ_WIDTH-1:0]  reading,
	input  wvd_pkg::ctrl_cmd_t              cmd,
	output wvd_pkg::dp_status_t             status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wvd_pkg::IDX_WIDTH-1:0]   direction
);

	wvd_pkg::count_t                 counts_q [wvd_pkg::NUM_BANDS];
	wvd_pkg::count_t                 best_q;
	logic [wvd_pkg::IDX_WIDTH-1:0]   best_idx_q;
	logic [wvd_pkg::IDX_WIDTH-1:0]   direction_q;
	logic                            out_valid_q;
	wvd_pkg::band_t                  band;
	logic [wvd_pkg::IDX_WIDTH-1:0]   rd_addr;
	wvd_pkg::count_t                 rd_data;
	logic                            take;
	logic [wvd_pkg::IDX_WIDTH-1:0]   winner;

	assign band    = wvd_pkg::band_of(reading);
	assign rd_addr = cmd.scan ? cmd.idx : band.code;
	assign rd_data = counts_q[rd_addr];

	// The first band always seeds the running maximum; later ones win only when strictly larger.
	assign take   = (cmd.idx == '0) || (best_q < rd_data);
	assign winner = take ? cmd.idx : best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wvd_pkg::NUM_BANDS; i++) counts_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.last) begin
				for (int i = 0; i < wvd_pkg::NUM_BANDS; i++) counts_q[i] <= '0;
			end else if (cmd.inc && band.hit && (rd_data != '1)) begin
				counts_q[rd_addr] <= rd_data + 1'b1;
			end
			if (cmd.last) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && take) begin
			best_q     <= rd_data;
			best_idx_q <= cmd.idx;
		end
		if (cmd.last) direction_q <= winner;
	end

	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign direction       = direction_q;

endmodule

### design/wind_vane_direction_mode.sv
// Wind vane direction mode finder.
// The input channel (in_valid, in_ready) carries an item made of mode and reading.
// A vane sample (mode 0) bumps the saturating counter of its compass band; a
// reading that sits on a band limit is dropped. Samples may arrive back to back,
// one per cycle, while no scan is running.
// An end-of-period item (mode 1) starts a scan over the eight band counters, one
// counter per cycle through a single read port, so the input is held off while
// the scan runs. The winning direction appears on the output channel (out_valid,
// out_ready, direction) in the cycle after the scan ends, and all counters are
// cleared at the same time.
// While a result waits for the receiver, samples are still taken; a further
// end-of-period item is held off until the waiting result has been taken.
// Reset clears all counters and empties the output register.
module wind_vane_direction_mode (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [wvd_pkg::READ_WIDTH-1:0]  reading,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wvd_pkg::IDX_WIDTH-1:0]   direction
);

	wvd_pkg::ctrl_cmd_t   cmd;
	wvd_pkg::dp_status_t  status;

	wvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.status   (status),
		.cmd      (cmd)
	);

	wvd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.reading   (reading),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.direction (direction)
	);

endmodule
